// ===== hdl/trs_pkg.sv =====
// trs_pkg: request and result types, fixed-point widths and the Q.36 to Q16.16
// rounding function for the TRS matrix composer. No dependencies.
package trs_pkg;

  // Fixed-point widths
  localparam int QUAT_W  = 16;   // Q2.14
  localparam int SCALE_W = 16;   // Q8.8
  localparam int POS_W   = 32;   // Q16.16
  localparam int OUT_W   = 32;   // Q16.16
  localparam int QPROD_W = 2 * QUAT_W;          // quaternion product, Q4.28
  localparam int ROT_W   = QPROD_W + 2;         // rotation element, Q4.28 with headroom
  localparam int PROD_W  = ROT_W + SCALE_W;     // rotation times scale, Q.36
  localparam int FRAC_SHIFT = 20;               // Q.36 down to Q16.16

  localparam logic signed [ROT_W-1:0] ONE_Q28 = ROT_W'(64'sd1 << 28);

  // One request: rotation, position, per-axis scale
  typedef struct packed {
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;
  } trs_in_t;

  // One result: top three rows of the affine matrix
  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m03;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m13;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
    logic signed [OUT_W-1:0] m23;
  } trs_out_t;

  // 3x3 rotation matrix in Q4.28
  typedef struct packed {
    logic signed [ROT_W-1:0] r00;
    logic signed [ROT_W-1:0] r01;
    logic signed [ROT_W-1:0] r02;
    logic signed [ROT_W-1:0] r10;
    logic signed [ROT_W-1:0] r11;
    logic signed [ROT_W-1:0] r12;
    logic signed [ROT_W-1:0] r20;
    logic signed [ROT_W-1:0] r21;
    logic signed [ROT_W-1:0] r22;
  } trs_rot_t;

  // Round half up (add half, floor) from Q.36 to Q16.16, then saturate
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W:0] t;
    logic signed [PROD_W:0] q;
    logic signed [PROD_W:0] max_v;
    logic signed [PROD_W:0] min_v;
    t = (PROD_W+1)'(v) + (PROD_W+1)'(64'sd1 <<< (FRAC_SHIFT - 1));
    q = t >>> FRAC_SHIFT;
    max_v = (PROD_W+1)'(64'sd2147483647);
    min_v = (PROD_W+1)'(-64'sd2147483648);
    if (q > max_v) begin
      return max_v[OUT_W-1:0];
    end else if (q < min_v) begin
      return min_v[OUT_W-1:0];
    end else begin
      return q[OUT_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/trs_rot_unit.sv =====
// trs_rot_unit: unit-quaternion to 3x3 rotation matrix, two register stages
// (products, then sums). Depends on trs_pkg.
module trs_rot_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [trs_pkg::QUAT_W-1:0] quat_w,
  input  logic signed [trs_pkg::QUAT_W-1:0] quat_x,
  input  logic signed [trs_pkg::QUAT_W-1:0] quat_y,
  input  logic signed [trs_pkg::QUAT_W-1:0] quat_z,
  output logic                              out_valid,
  output trs_pkg::trs_rot_t                 rot
);

  // Stage 1: the nine component products
  logic signed [trs_pkg::QPROD_W-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
  logic signed [trs_pkg::QPROD_W-1:0] p_wx, p_wy, p_wz;
  logic                               v1;

  always_ff @(posedge clk) begin
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_zz <= quat_z * quat_z;
    p_xy <= quat_x * quat_y;
    p_xz <= quat_x * quat_z;
    p_yz <= quat_y * quat_z;
    p_wx <= quat_w * quat_x;
    p_wy <= quat_w * quat_y;
    p_wz <= quat_w * quat_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  // Stage 2: matrix elements, 1 - 2(a+b) on the diagonal, 2(a +/- b) elsewhere
  localparam int RW = trs_pkg::ROT_W;
  trs_pkg::trs_rot_t rot_next;

  always_comb begin
    rot_next.r00 = trs_pkg::ONE_Q28 - ((RW'(p_yy) + RW'(p_zz)) <<< 1);
    rot_next.r01 = (RW'(p_xy) - RW'(p_wz)) <<< 1;
    rot_next.r02 = (RW'(p_xz) + RW'(p_wy)) <<< 1;
    rot_next.r10 = (RW'(p_xy) + RW'(p_wz)) <<< 1;
    rot_next.r11 = trs_pkg::ONE_Q28 - ((RW'(p_xx) + RW'(p_zz)) <<< 1);
    rot_next.r12 = (RW'(p_yz) - RW'(p_wx)) <<< 1;
    rot_next.r20 = (RW'(p_xz) - RW'(p_wy)) <<< 1;
    rot_next.r21 = (RW'(p_yz) + RW'(p_wx)) <<< 1;
    rot_next.r22 = trs_pkg::ONE_Q28 - ((RW'(p_xx) + RW'(p_yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    rot <= rot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
  end

endmodule

// ===== hdl/trs_matrix_compose.sv =====
// trs_matrix_compose: top level, translation * rotation * scale to a 3x4 affine matrix.
// Depends on trs_pkg and trs_rot_unit.
//
//   channel   direction   handshake        payload
//   request   in          start / busy     xform  (trs_pkg::trs_in_t)
//   result    out         done (strobe)    matrix (trs_pkg::trs_out_t)
//
// One request per cycle; each result passes through the stage registers in order:
// quaternion products, rotation sums,
// scale multiply, round and saturate.
// busy is high only during reset and the cycle after; there are no stalls.
// Reset clears the valid bits of all stages; data registers are not reset.
// done is a one-cycle strobe and the receiver cannot hold it off.
module trs_matrix_compose (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  trs_pkg::trs_in_t  xform,
  output logic              done,
  output trs_pkg::trs_out_t matrix
);

  localparam int PW = trs_pkg::PROD_W;

  logic accept;
  assign accept = start && !busy;

  // Busy only around reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Stages 1 and 2: rotation matrix
  trs_pkg::trs_rot_t rot;
  logic              v2;

  trs_rot_unit u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .quat_w    (xform.quat_w),
    .quat_x    (xform.quat_x),
    .quat_y    (xform.quat_y),
    .quat_z    (xform.quat_z),
    .out_valid (v2),
    .rot       (rot)
  );

  // Side data follows the rotation unit
  logic signed [trs_pkg::SCALE_W-1:0] sx1, sy1, sz1, sx2, sy2, sz2;
  logic signed [trs_pkg::POS_W-1:0]   px1, py1, pz1, px2, py2, pz2, px3, py3, pz3;

  always_ff @(posedge clk) begin
    sx1 <= xform.scale_x;
    sy1 <= xform.scale_y;
    sz1 <= xform.scale_z;
    sx2 <= sx1;
    sy2 <= sy1;
    sz2 <= sz1;
    px1 <= xform.pos_x;
    py1 <= xform.pos_y;
    pz1 <= xform.pos_z;
    px2 <= px1;
    py2 <= py1;
    pz2 <= pz1;
    px3 <= px2;
    py3 <= py2;
    pz3 <= pz2;
  end

  // Stage 3: scale each column by its axis
  logic signed [PW-1:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;
  logic                 v3;

  always_ff @(posedge clk) begin
    q00 <= PW'(rot.r00) * PW'(sx2);
    q10 <= PW'(rot.r10) * PW'(sx2);
    q20 <= PW'(rot.r20) * PW'(sx2);
    q01 <= PW'(rot.r01) * PW'(sy2);
    q11 <= PW'(rot.r11) * PW'(sy2);
    q21 <= PW'(rot.r21) * PW'(sy2);
    q02 <= PW'(rot.r02) * PW'(sz2);
    q12 <= PW'(rot.r12) * PW'(sz2);
    q22 <= PW'(rot.r22) * PW'(sz2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  // Stage 4: round to Q16.16, saturate, register the result
  always_ff @(posedge clk) begin
    matrix.m00 <= trs_pkg::round_sat(q00);
    matrix.m01 <= trs_pkg::round_sat(q01);
    matrix.m02 <= trs_pkg::round_sat(q02);
    matrix.m03 <= px3;
    matrix.m10 <= trs_pkg::round_sat(q10);
    matrix.m11 <= trs_pkg::round_sat(q11);
    matrix.m12 <= trs_pkg::round_sat(q12);
    matrix.m13 <= py3;
    matrix.m20 <= trs_pkg::round_sat(q20);
    matrix.m21 <= trs_pkg::round_sat(q21);
    matrix.m22 <= trs_pkg::round_sat(q22);
    matrix.m23 <= pz3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  // Each request yields exactly one strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, 4))
    else $error("result strobe does not match request four cycles back");

  // Translation column comes straight through the delay line
  a_pos_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> (matrix.m03 == $past(xform.pos_x, 4)) && (matrix.m23 == $past(xform.pos_z, 4)))
    else $error("translation not carried with its request");

  // Identity rotation with unit x scale gives a unit first column
  a_identity: assert property (@(posedge clk) disable iff (rst)
    done && $past(xform.quat_w == 16'sh4000 && xform.quat_x == 16'sh0 &&
                  xform.quat_y == 16'sh0 && xform.quat_z == 16'sh0 &&
                  xform.scale_x == 16'sh0100, 4)
    |-> (matrix.m00 == 32'sh0001_0000) && (matrix.m10 == 32'sh0) && (matrix.m20 == 32'sh0))
    else $error("identity quaternion did not give unit column");

  // No back-pressure once out of reset
  a_never_busy: assert property (@(posedge clk)
    !rst && !$past(rst) |-> !busy)
    else $error("busy raised outside reset");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for trs_matrix_compose, driving transforms and checking matrices
// against an in-bench predictor. Depends on trs_pkg and trs_matrix_compose.
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NUM_FIELDS     = 12;
  localparam int OUT_W          = trs_pkg::OUT_W;
  localparam int POS_W          = trs_pkg::POS_W;
  localparam int FRAC_SHIFT     = trs_pkg::FRAC_SHIFT;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  trs_pkg::trs_in_t  xform;
  logic              done;
  trs_pkg::trs_out_t matrix;

  // Matrices still owed by the block, oldest first
  trs_pkg::trs_out_t pending_matrices[$];

  int sender_idle_pct = 0;
  int n_requests      = 0;
  int n_matrices      = 0;
  int n_errors        = 0;

  string field_names[NUM_FIELDS] = '{"m00", "m01", "m02", "m03",
                                     "m10", "m11", "m12", "m13",
                                     "m20", "m21", "m22", "m23"};

  trs_matrix_compose DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .xform  (xform),
    .done   (done),
    .matrix (matrix)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Q.36 to Q16.16: add half, floor, clamp to 32 bits
  function automatic logic [OUT_W-1:0] round_q16(input longint v);
    longint q;
    q = (v + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[OUT_W-1:0];
  endfunction

  // Expected affine matrix: translation * rotation * scale
  function automatic trs_pkg::trs_out_t compose_matrix(input trs_pkg::trs_in_t xf);
    longint   qw, qx, qy, qz;
    longint   one_q28;
    longint   sc[3];
    longint   rot[3][3];
    logic [POS_W-1:0] pos[3];
    trs_pkg::trs_out_t m;
    qw = longint'($signed(xf.quat_w));
    qx = longint'($signed(xf.quat_x));
    qy = longint'($signed(xf.quat_y));
    qz = longint'($signed(xf.quat_z));
    sc[0] = longint'($signed(xf.scale_x));
    sc[1] = longint'($signed(xf.scale_y));
    sc[2] = longint'($signed(xf.scale_z));
    pos[0] = xf.pos_x;
    pos[1] = xf.pos_y;
    pos[2] = xf.pos_z;
    one_q28 = 64'sd1 <<< 28;
    rot[0][0] = one_q28 - 2 * (qy * qy + qz * qz);
    rot[0][1] = 2 * (qx * qy - qw * qz);
    rot[0][2] = 2 * (qx * qz + qw * qy);
    rot[1][0] = 2 * (qx * qy + qw * qz);
    rot[1][1] = one_q28 - 2 * (qx * qx + qz * qz);
    rot[1][2] = 2 * (qy * qz - qw * qx);
    rot[2][0] = 2 * (qx * qz - qw * qy);
    rot[2][1] = 2 * (qy * qz + qw * qx);
    rot[2][2] = one_q28 - 2 * (qx * qx + qy * qy);
    m = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[(NUM_FIELDS - 1 - (r * 4 + c)) * OUT_W +: OUT_W] = round_q16(rot[r][c] * sc[c]);
      end
      // translation passes straight through
      m[(NUM_FIELDS - 1 - (r * 4 + 3)) * OUT_W +: OUT_W] = pos[r];
    end
    return m;
  endfunction

  function automatic trs_pkg::trs_in_t make_xform(input logic [15:0] qw, qx, qy, qz,
                                                  input logic [31:0] px, py, pz,
                                                  input logic [15:0] sx, sy, sz);
    trs_pkg::trs_in_t xf;
    xf.quat_w  = qw;
    xf.quat_x  = qx;
    xf.quat_y  = qy;
    xf.quat_z  = qz;
    xf.pos_x   = px;
    xf.pos_y   = py;
    xf.pos_z   = pz;
    xf.scale_x = sx;
    xf.scale_y = sy;
    xf.scale_z = sz;
    return xf;
  endfunction

  // Random transform: raw bits, bounded quaternions and scales, or axis-aligned turns
  function automatic trs_pkg::trs_in_t random_xform();
    trs_pkg::trs_in_t xf;
    logic [223:0]     raw;
    int               mode;
    int               axis;
    mode = $urandom_range(3);
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    xf = raw[$bits(trs_pkg::trs_in_t)-1:0];
    if (mode == 2) begin
      xf.quat_w  = 16'($urandom_range(23170)) - 16'sd11585;
      xf.quat_x  = 16'($urandom_range(23170)) - 16'sd11585;
      xf.quat_y  = 16'($urandom_range(23170)) - 16'sd11585;
      xf.quat_z  = 16'($urandom_range(23170)) - 16'sd11585;
      xf.scale_x = 16'($urandom_range(4096)) - 16'sd2048;
      xf.scale_y = 16'($urandom_range(4096)) - 16'sd2048;
      xf.scale_z = 16'($urandom_range(4096)) - 16'sd2048;
    end else if (mode == 3) begin
      axis = $urandom_range(3);
      xf.quat_w = (axis == 0) ? 16'sd16384 : 16'sd0;
      xf.quat_x = (axis == 1) ? 16'sd16384 : 16'sd0;
      xf.quat_y = (axis == 2) ? 16'sd16384 : 16'sd0;
      xf.quat_z = (axis == 3) ? 16'sd16384 : 16'sd0;
      if ($urandom_range(1)) xf.quat_w = -xf.quat_w;
    end
    return xf;
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_xform(input trs_pkg::trs_in_t xf);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    xform = xf;
    do @(posedge clk); while (busy);
    pending_matrices.push_back(compose_matrix(xf));
    n_requests++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    trs_pkg::trs_out_t want;
    logic [OUT_W-1:0] want_f, got_f;
    if (!rst && done) begin
      n_matrices++;
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected matrix 0x%h", $time, matrix);
        n_errors++;
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < NUM_FIELDS; i++) begin
          want_f = want[(NUM_FIELDS - 1 - i) * OUT_W +: OUT_W];
          got_f  = matrix[(NUM_FIELDS - 1 - i) * OUT_W +: OUT_W];
          if (want_f !== got_f) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, field_names[i],
                     $signed(want_f), $signed(got_f));
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long with neither a request nor a result taken
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((!rst && start && !busy) || (!rst && done)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog expired with %0d matrices outstanding", $time,
             pending_matrices.size());
    $display("Some tests failed");
    $finish;
  end

  // Identity, half-turns about each axis and a quarter turn about z
  task automatic test_basic_rotations();
    send_xform(make_xform(16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                          32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                          16'sd256, 16'sd256, 16'sd256));
    send_xform(make_xform(16'sd0, 16'sd16384, 16'sd0, 16'sd0,
                          32'h1234_5678, 32'h8765_4321, 32'h0,
                          16'sd256, 16'sd512, -16'sd256));
    send_xform(make_xform(16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                          16'sd128, 16'sd256, 16'sd384));
    send_xform(make_xform(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'h0, 32'h0,
                          -16'sd256, -16'sd256, -16'sd256));
    // quarter turn about z: w = z = sqrt(1/2)
    send_xform(make_xform(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 32'h0, 32'h0, 32'h0,
                          16'sd256, 16'sd256, 16'sd256));
  endtask

  // Field extremes and bit patterns
  task automatic test_field_extremes();
    send_xform(make_xform(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_xform(make_xform(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          16'h8000, 16'h8000, 16'h8000));
    send_xform(make_xform(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 32'h0, 32'h0, 32'h0,
                          16'h7FFF, 16'h8000, 16'h7FFF));
    send_xform(make_xform(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 32'h0, 32'h0, 32'h0,
                          16'h8000, 16'h7FFF, 16'h8000));
    send_xform('0);
    send_xform('1);
    send_xform({13{16'h5555}});
    send_xform(make_xform(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          16'hAAAA, 16'h5555, 16'hAAAA));
    send_xform(make_xform(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          16'h5555, 16'hAAAA, 16'h5555));
  endtask

  // Rounding ties, sign of zero results, non-unit quaternions
  task automatic test_rounding_and_non_unit();
    // 2*x*y = 2^19 gives exactly half an output unit: ties go up
    send_xform(make_xform(16'sd0, 16'sd16, 16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0,
                          16'sd1, 16'sd1, 16'sd1));
    send_xform(make_xform(16'sd0, 16'sd16, 16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0,
                          -16'sd1, -16'sd1, -16'sd1));
    send_xform(make_xform(16'sd0, 16'sd16, 16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0,
                          16'sd3, -16'sd3, 16'sd3));
    // one below and one above the tie
    send_xform(make_xform(16'sd0, 16'sd15, 16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0,
                          16'sd1, 16'sd1, -16'sd1));
    send_xform(make_xform(16'sd0, 16'sd17, 16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0,
                          -16'sd1, 16'sd1, 16'sd1));
    // zero quaternion: the formula degenerates to identity
    send_xform(make_xform(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0,
                          16'sd300, -16'sd300, 16'sd1));
    // quaternion of length two, then a longer one
    send_xform(make_xform(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0,
                          16'sd256, 16'sd256, 16'sd256));
    send_xform(make_xform(16'sd20000, -16'sd20000, 16'sd20000, -16'sd20000, 32'h0, 32'h0,
                          32'h0, 16'sd7000, -16'sd7000, 16'sd7000));
  endtask

  task automatic test_random(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) send_xform(random_xform());
  endtask

  // Sequence
  initial begin
    rst   = 1'b1;
    start = 1'b0;
    xform = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_basic_rotations();
    test_field_extremes();
    test_rounding_and_non_unit();
    test_random(170, 8);
    test_random(170, 63);
    test_random(160, 0);

    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transforms (half-turns, field extremes, rounding ties, non-unit",
             n_requests);
    $display("quaternions, random) with request gaps of 8%%, 63%% and none; %0d matrices checked",
             n_matrices);
    if (n_errors == 0 && pending_matrices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/trs_pkg.sv
hdl/trs_rot_unit.sv
hdl/trs_matrix_compose.sv
bench/tb.sv
